[src/tcpq_pkg.sv]
`default_nettype none

package tcpq_pkg;

	// Defaults for the top-level parameters
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF     = 16;

	// Fixed port widths
	localparam int ID_W     = 16;
	localparam int CAT_W    = 4;
	localparam int STATUS_W = 3;
	localparam int CLS_W    = 2;

	localparam int NUM_CLASSES = 3;

	// Operation codes
	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_SERVE   = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_ENQUEUED     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_SERVED       = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY        = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_CATEGORY = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL         = 3'd4;

	// Priority classes
	localparam logic [CLS_W-1:0] CLS_HIGH = 2'd0;
	localparam logic [CLS_W-1:0] CLS_MED  = 2'd1;
	localparam logic [CLS_W-1:0] CLS_LOW  = 2'd2;

	// Category code ranges
	localparam logic [CAT_W-1:0] CAT_HIGH_LO = 4'd1;
	localparam logic [CAT_W-1:0] CAT_HIGH_HI = 4'd4;
	localparam logic [CAT_W-1:0] CAT_MED_LO  = 4'd5;
	localparam logic [CAT_W-1:0] CAT_MED_HI  = 4'd7;
	localparam logic [CAT_W-1:0] CAT_LOW     = 4'd8;

	// Outcome of one request, carried from the decision stage to the result stage
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CLS_W-1:0]    cls;
		logic                served;
	} res_t;

endpackage

`default_nettype wire

[src/tcpq_store.sv]
`default_nettype none

module tcpq_store #(
	parameter int NUM_ENTRIES = 3 * tcpq_pkg::QUEUE_DEPTH_DEF,
	parameter int DATA_W      = tcpq_pkg::ID_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           wr_en,
	input  wire logic [$clog2(NUM_ENTRIES)-1:0] wr_addr,
	input  wire logic [DATA_W-1:0]              wr_data,
	input  wire logic                           rd_en,
	input  wire logic [$clog2(NUM_ENTRIES)-1:0] rd_addr,
	output logic      [DATA_W-1:0]              rd_data
);

	logic [DATA_W-1:0] mem [NUM_ENTRIES];
	logic [DATA_W-1:0] rd_data_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[src/tcpq_ctrl.sv]
`default_nettype none

module tcpq_ctrl #(
	parameter int QUEUE_DEPTH = tcpq_pkg::QUEUE_DEPTH_DEF,
	parameter int DATA_W      = tcpq_pkg::ID_BITS_DEF,
	localparam int PTR_W      = $clog2(QUEUE_DEPTH),
	localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
	localparam int ADDR_W     = $clog2(tcpq_pkg::NUM_CLASSES * QUEUE_DEPTH)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       valid_s1,
	input  wire logic                       op_s1,
	input  wire logic [DATA_W-1:0]          id_s1,
	input  wire logic [tcpq_pkg::CAT_W-1:0] cat_s1,
	output logic                            wr_en,
	output logic      [ADDR_W-1:0]          wr_addr,
	output logic      [DATA_W-1:0]          wr_data,
	output logic                            rd_en,
	output logic      [ADDR_W-1:0]          rd_addr,
	output tcpq_pkg::res_t                  res
);

	logic [PTR_W-1:0] head_q [tcpq_pkg::NUM_CLASSES];
	logic [PTR_W-1:0] tail_q [tcpq_pkg::NUM_CLASSES];
	logic [CNT_W-1:0] cnt_q  [tcpq_pkg::NUM_CLASSES];

	logic                       cat_ok;
	logic [tcpq_pkg::CLS_W-1:0] cat_cls;
	logic [tcpq_pkg::CLS_W-1:0] sel_cls;

	function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	function automatic logic [ADDR_W-1:0] base(input logic [tcpq_pkg::CLS_W-1:0] c);
		logic [ADDR_W-1:0] b;
		unique case (c)
			tcpq_pkg::CLS_HIGH: b = '0;
			tcpq_pkg::CLS_MED:  b = ADDR_W'(QUEUE_DEPTH);
			default:            b = ADDR_W'(2 * QUEUE_DEPTH);
		endcase
		return b;
	endfunction

	// Category decode
	always_comb begin
		cat_ok  = 1'b1;
		cat_cls = tcpq_pkg::CLS_HIGH;
		unique case (cat_s1) inside
			[tcpq_pkg::CAT_HIGH_LO:tcpq_pkg::CAT_HIGH_HI]: cat_cls = tcpq_pkg::CLS_HIGH;
			[tcpq_pkg::CAT_MED_LO:tcpq_pkg::CAT_MED_HI]:   cat_cls = tcpq_pkg::CLS_MED;
			tcpq_pkg::CAT_LOW:                             cat_cls = tcpq_pkg::CLS_LOW;
			default:                                       cat_ok  = 1'b0;
		endcase
	end

	// Strict-priority pick for serve requests
	always_comb begin
		if (cnt_q[0] != '0) begin
			sel_cls = tcpq_pkg::CLS_HIGH;
		end else if (cnt_q[1] != '0) begin
			sel_cls = tcpq_pkg::CLS_MED;
		end else begin
			sel_cls = tcpq_pkg::CLS_LOW;
		end
	end

	// Decision for the request in stage 1
	always_comb begin
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		wr_addr    = base(cat_cls) + ADDR_W'(tail_q[cat_cls]);
		rd_addr    = base(sel_cls) + ADDR_W'(head_q[sel_cls]);
		wr_data    = id_s1;
		res.status = tcpq_pkg::ST_EMPTY;
		res.cls    = tcpq_pkg::CLS_HIGH;
		res.served = 1'b0;
		if (valid_s1) begin
			if (op_s1 == tcpq_pkg::OP_ENQUEUE) begin
				if (!cat_ok) begin
					res.status = tcpq_pkg::ST_BAD_CATEGORY;
				end else if (cnt_q[cat_cls] == CNT_W'(QUEUE_DEPTH)) begin
					res.status = tcpq_pkg::ST_FULL;
					res.cls    = cat_cls;
				end else begin
					wr_en      = 1'b1;
					res.status = tcpq_pkg::ST_ENQUEUED;
					res.cls    = cat_cls;
				end
			end else if (cnt_q[sel_cls] != '0) begin
				rd_en      = 1'b1;
				res.status = tcpq_pkg::ST_SERVED;
				res.cls    = sel_cls;
				res.served = 1'b1;
			end
		end
	end

	// Pointer and occupancy update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < tcpq_pkg::NUM_CLASSES; c++) begin
				head_q[c] <= '0;
				tail_q[c] <= '0;
				cnt_q[c]  <= '0;
			end
		end else begin
			for (int c = 0; c < tcpq_pkg::NUM_CLASSES; c++) begin
				if (wr_en && cat_cls == tcpq_pkg::CLS_W'(c)) begin
					tail_q[c] <= adv(tail_q[c]);
					cnt_q[c]  <= cnt_q[c] + 1'b1;
				end
				if (rd_en && sel_cls == tcpq_pkg::CLS_W'(c)) begin
					head_q[c] <= adv(head_q[c]);
					cnt_q[c]  <= cnt_q[c] - 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

[src/three_class_priority_queue_unit.sv]
// Three-class strict-priority queue. A request is taken on every clock edge where
// start is high; busy is always low, so one request per cycle is sustained. Each
// request yields exactly one result, shown for one cycle with done high, after it has
// passed the request register, then the decision with the result register and
// the registered read of the entry memory. Results are in request order and cannot
// be stalled. The entry memory needs no clearing after reset; only occupied slots
// are ever read.
`default_nettype none

module three_class_priority_queue_unit #(
	parameter int QUEUE_DEPTH = tcpq_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_BITS     = tcpq_pkg::ID_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          operation,
	input  wire logic [tcpq_pkg::ID_W-1:0]     entry_id,
	input  wire logic [tcpq_pkg::CAT_W-1:0]    category,
	output logic                               done,
	output logic      [tcpq_pkg::STATUS_W-1:0] status,
	output logic      [tcpq_pkg::ID_W-1:0]     served_id,
	output logic      [tcpq_pkg::CLS_W-1:0]    served_class
);

	localparam int STORE_W     = (ID_BITS < tcpq_pkg::ID_W) ? ID_BITS : tcpq_pkg::ID_W;
	localparam int NUM_ENTRIES = tcpq_pkg::NUM_CLASSES * QUEUE_DEPTH;
	localparam int ADDR_W      = $clog2(NUM_ENTRIES);

	logic                       valid_s1;
	logic                       op_s1;
	logic [STORE_W-1:0]         id_s1;
	logic [tcpq_pkg::CAT_W-1:0] cat_s1;

	logic                       valid_s2;
	tcpq_pkg::res_t             res_s2;

	logic                       wr_en;
	logic [ADDR_W-1:0]          wr_addr;
	logic [STORE_W-1:0]         wr_data;
	logic                       rd_en;
	logic [ADDR_W-1:0]          rd_addr;
	logic [STORE_W-1:0]         rd_data;
	tcpq_pkg::res_t             res;

	assign busy = 1'b0;

	// Request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		op_s1  <= operation;
		id_s1  <= entry_id[STORE_W-1:0];
		cat_s1 <= category;
	end

	tcpq_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.DATA_W      (STORE_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.op_s1    (op_s1),
		.id_s1    (id_s1),
		.cat_s1   (cat_s1),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.res      (res)
	);

	tcpq_store #(
		.NUM_ENTRIES (NUM_ENTRIES),
		.DATA_W      (STORE_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		res_s2 <= res;
	end

	assign done         = valid_s2;
	assign status       = res_s2.status;
	assign served_class = res_s2.cls;
	assign served_id    = res_s2.served ? tcpq_pkg::ID_W'(rd_data) : '0;

endmodule

`default_nettype wire

[src/tcpq_chk.sv]
`default_nettype none

module tcpq_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic                          operation,
	input wire logic [tcpq_pkg::CAT_W-1:0]    category,
	input wire logic                          done,
	input wire logic [tcpq_pkg::STATUS_W-1:0] status,
	input wire logic [tcpq_pkg::ID_W-1:0]     served_id,
	input wire logic [tcpq_pkg::CLS_W-1:0]    served_class
);

	// Every request gets its result through the request and result registers
	a_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("request without result");

	// No result appears without a request
	a_done_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without request");

	// Bad category on enqueue is reported as such
	a_bad_cat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == tcpq_pkg::OP_ENQUEUE &&
		 (category < tcpq_pkg::CAT_HIGH_LO || category > tcpq_pkg::CAT_LOW))
		|-> ##2 (done && status == tcpq_pkg::ST_BAD_CATEGORY && served_class == '0))
		else $error("bad category not flagged");

	// Only a served result carries an identifier
	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != tcpq_pkg::ST_SERVED) |-> (served_id == '0))
		else $error("identifier on non-serve result");

endmodule

bind three_class_priority_queue_unit tcpq_chk u_tcpq_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.operation    (operation),
	.category     (category),
	.done         (done),
	.status       (status),
	.served_id    (served_id),
	.served_class (served_class)
);

`default_nettype wire

[dv/tb_three_class_priority_queue_unit.sv]
module tb_three_class_priority_queue_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QDEPTH   = tcpq_pkg::QUEUE_DEPTH_DEF;
	localparam int ID_KEEP_BITS = tcpq_pkg::ID_BITS_DEF;
	localparam logic [tcpq_pkg::ID_W-1:0] ID_KEEP =
		(ID_KEEP_BITS >= tcpq_pkg::ID_W) ? {tcpq_pkg::ID_W{1'b1}} :
		tcpq_pkg::ID_W'((64'd1 << ID_KEEP_BITS) - 1);
	localparam int NUM_RANDOM = 900;

	// One result of the queue
	typedef struct packed {
		logic [tcpq_pkg::STATUS_W-1:0] status;
		logic [tcpq_pkg::ID_W-1:0]     id;
		logic [tcpq_pkg::CLS_W-1:0]    cls;
	} outcome_t;

	localparam outcome_t NO_HAND = '0;

	// Hand-typed results for the directed rows
	localparam outcome_t EXP_EMPTY =
		'{tcpq_pkg::ST_EMPTY, 16'h0, tcpq_pkg::CLS_HIGH};
	localparam outcome_t EXP_BAD =
		'{tcpq_pkg::ST_BAD_CATEGORY, 16'h0, tcpq_pkg::CLS_HIGH};
	localparam outcome_t EXP_ENQ_HIGH =
		'{tcpq_pkg::ST_ENQUEUED, 16'h0, tcpq_pkg::CLS_HIGH};
	localparam outcome_t EXP_ENQ_MED =
		'{tcpq_pkg::ST_ENQUEUED, 16'h0, tcpq_pkg::CLS_MED};
	localparam outcome_t EXP_ENQ_LOW =
		'{tcpq_pkg::ST_ENQUEUED, 16'h0, tcpq_pkg::CLS_LOW};
	localparam outcome_t EXP_FULL_LOW =
		'{tcpq_pkg::ST_FULL, 16'h0, tcpq_pkg::CLS_LOW};

	// Directed row: request fields, repeat count, optional hand-typed result
	typedef struct packed {
		logic                          op;
		logic [tcpq_pkg::ID_W-1:0]     id;
		logic [tcpq_pkg::CAT_W-1:0]    cat;
		logic [5:0]                    reps;
		logic                          typed;
		outcome_t                      want;
	} stim_row_t;

	localparam int NUM_ROWS = 23;
	localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
		// serve right after reset: everything empty
		'{tcpq_pkg::OP_SERVE,   16'h0000, 4'd0,  6'd1,  1'b1, EXP_EMPTY},
		// rejected category codes
		'{tcpq_pkg::OP_ENQUEUE, 16'hFFFF, 4'd0,  6'd1,  1'b1, EXP_BAD},
		'{tcpq_pkg::OP_ENQUEUE, 16'h0000, 4'd15, 6'd1,  1'b1, EXP_BAD},
		'{tcpq_pkg::OP_ENQUEUE, 16'hAAAA, 4'd9,  6'd1,  1'b1, EXP_BAD},
		// every valid code lands in its class
		'{tcpq_pkg::OP_ENQUEUE, 16'hFFFF, 4'd8,  6'd1,  1'b1, EXP_ENQ_LOW},
		'{tcpq_pkg::OP_ENQUEUE, 16'h0000, 4'd5,  6'd1,  1'b1, EXP_ENQ_MED},
		'{tcpq_pkg::OP_ENQUEUE, 16'h1357, 4'd6,  6'd1,  1'b1, EXP_ENQ_MED},
		'{tcpq_pkg::OP_ENQUEUE, 16'h2468, 4'd7,  6'd1,  1'b1, EXP_ENQ_MED},
		'{tcpq_pkg::OP_ENQUEUE, 16'h0001, 4'd1,  6'd1,  1'b1, EXP_ENQ_HIGH},
		'{tcpq_pkg::OP_ENQUEUE, 16'h8000, 4'd4,  6'd1,  1'b1, EXP_ENQ_HIGH},
		'{tcpq_pkg::OP_ENQUEUE, 16'h5555, 4'd2,  6'd1,  1'b0, NO_HAND},
		'{tcpq_pkg::OP_ENQUEUE, 16'h7FFF, 4'd3,  6'd1,  1'b0, NO_HAND},
		// drain high, then start on medium
		'{tcpq_pkg::OP_SERVE,   16'hFFFF, 4'd15, 6'd4,  1'b0, NO_HAND},
		'{tcpq_pkg::OP_SERVE,   16'h0000, 4'd8,  6'd1,  1'b0, NO_HAND},
		// a new high entry jumps ahead of what is left
		'{tcpq_pkg::OP_ENQUEUE, 16'hC3C3, 4'd1,  6'd1,  1'b0, NO_HAND},
		'{tcpq_pkg::OP_SERVE,   16'h1234, 4'd0,  6'd2,  1'b0, NO_HAND},
		'{tcpq_pkg::OP_SERVE,   16'h0000, 4'd0,  6'd3,  1'b0, NO_HAND},
		'{tcpq_pkg::OP_SERVE,   16'h0000, 4'd0,  6'd1,  1'b1, EXP_EMPTY},
		// fill low past its wrap point, then one more is dropped
		'{tcpq_pkg::OP_ENQUEUE, 16'hBEEF, 4'd8,  6'd16, 1'b0, NO_HAND},
		'{tcpq_pkg::OP_ENQUEUE, 16'h0000, 4'd8,  6'd1,  1'b1, EXP_FULL_LOW},
		'{tcpq_pkg::OP_ENQUEUE, 16'hFFFF, 4'd10, 6'd1,  1'b1, EXP_BAD},
		'{tcpq_pkg::OP_SERVE,   16'h0000, 4'd0,  6'd16, 1'b0, NO_HAND},
		'{tcpq_pkg::OP_SERVE,   16'hFFFF, 4'd15, 6'd1,  1'b1, EXP_EMPTY}
	};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	logic                          operation = tcpq_pkg::OP_ENQUEUE;
	logic [tcpq_pkg::ID_W-1:0]     entry_id = '0;
	logic [tcpq_pkg::CAT_W-1:0]    category = '0;
	logic                          done;
	logic [tcpq_pkg::STATUS_W-1:0] status;
	logic [tcpq_pkg::ID_W-1:0]     served_id;
	logic [tcpq_pkg::CLS_W-1:0]    served_class;

	// Side info that travels with the request, driven along with start
	logic     req_typed = 1'b0;
	outcome_t req_hand = '0;

	// Shadow queue state
	logic [tcpq_pkg::ID_W-1:0] shadow_ids [tcpq_pkg::NUM_CLASSES][QDEPTH];
	int              shadow_head  [tcpq_pkg::NUM_CLASSES] = '{0, 0, 0};
	int              shadow_tail  [tcpq_pkg::NUM_CLASSES] = '{0, 0, 0};
	int              shadow_count [tcpq_pkg::NUM_CLASSES] = '{0, 0, 0};

	outcome_t pending_outcomes [$];
	int       mismatch_count = 0;

	three_class_priority_queue_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.entry_id     (entry_id),
		.category     (category),
		.done         (done),
		.status       (status),
		.served_id    (served_id),
		.served_class (served_class)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("three_class_priority_queue_unit: mismatch");
		$finish;
	end

	// Apply one request to the shadow queues and return its result
	function automatic outcome_t predict_outcome(input logic op,
		input logic [tcpq_pkg::ID_W-1:0] id, input logic [tcpq_pkg::CAT_W-1:0] cat);
		outcome_t o;
		int       c;
		o = '{tcpq_pkg::ST_EMPTY, '0, tcpq_pkg::CLS_HIGH};
		c = -1;
		if (op == tcpq_pkg::OP_ENQUEUE) begin
			if (cat >= tcpq_pkg::CAT_HIGH_LO && cat <= tcpq_pkg::CAT_HIGH_HI)
				c = int'(tcpq_pkg::CLS_HIGH);
			else if (cat >= tcpq_pkg::CAT_MED_LO && cat <= tcpq_pkg::CAT_MED_HI)
				c = int'(tcpq_pkg::CLS_MED);
			else if (cat == tcpq_pkg::CAT_LOW)
				c = int'(tcpq_pkg::CLS_LOW);
			if (c < 0) begin
				o.status = tcpq_pkg::ST_BAD_CATEGORY;
			end else if (shadow_count[c] >= QDEPTH) begin
				o.status = tcpq_pkg::ST_FULL;
				o.cls    = tcpq_pkg::CLS_W'(c);
			end else begin
				shadow_ids[c][shadow_tail[c]] = id & ID_KEEP;
				shadow_tail[c]  = (shadow_tail[c] + 1 >= QDEPTH) ? 0 : shadow_tail[c] + 1;
				shadow_count[c] = shadow_count[c] + 1;
				o.status = tcpq_pkg::ST_ENQUEUED;
				o.cls    = tcpq_pkg::CLS_W'(c);
			end
			return o;
		end
		// strict priority pick
		for (int k = 0; k < tcpq_pkg::NUM_CLASSES; k++) begin
			if (shadow_count[k] != 0) begin
				o.status = tcpq_pkg::ST_SERVED;
				o.id     = shadow_ids[k][shadow_head[k]];
				o.cls    = tcpq_pkg::CLS_W'(k);
				shadow_head[k]  = (shadow_head[k] + 1 >= QDEPTH) ? 0 : shadow_head[k] + 1;
				shadow_count[k] = shadow_count[k] - 1;
				return o;
			end
		end
		return o;
	endfunction

	task automatic report_field(input string label, input logic [tcpq_pkg::ID_W-1:0] want,
		input logic [tcpq_pkg::ID_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h got %0h", $time, label, want, got);
			mismatch_count++;
		end
	endtask

	// Request capture and result check, both on the sampled edge
	always @(posedge clk) begin
		outcome_t want;
		outcome_t model;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t: unexpected result status %0h id %0h class %0h", $time,
					status, served_id, served_class);
				mismatch_count++;
			end else begin
				want = pending_outcomes.pop_front();
				report_field("status", tcpq_pkg::ID_W'(want.status),
					tcpq_pkg::ID_W'(status));
				report_field("served_id", want.id, served_id);
				report_field("served_class", tcpq_pkg::ID_W'(want.cls),
					tcpq_pkg::ID_W'(served_class));
			end
		end
		if (arst_n && start && !busy) begin
			model = predict_outcome(operation, entry_id, category);
			pending_outcomes.push_back(req_typed ? req_hand : model);
		end
	end

	// Present a request and hold it until taken
	task automatic issue_request(input logic op, input logic [tcpq_pkg::ID_W-1:0] id,
		input logic [tcpq_pkg::CAT_W-1:0] cat, input logic typed, input outcome_t hand);
		start     <= 1'b1;
		operation <= op;
		entry_id  <= id;
		category  <= cat;
		req_typed <= typed;
		req_hand  <= hand;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_for(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Stop sending until every outstanding result is back
	task automatic wait_for_outcomes();
		start <= 1'b0;
		@(posedge clk);
		while (pending_outcomes.size() != 0) @(posedge clk);
	endtask

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap(input bit calm);
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin
		stim_row_t                  row;
		logic                       op;
		logic [tcpq_pkg::CAT_W-1:0] cat;
		int                         enq_pct;
		bit                         calm;
		int                         r;
		enq_pct = 50;
		calm    = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int k = 0; k < NUM_ROWS; k++) begin
			row = DIRECTED_ROWS[k];
			repeat (int'(row.reps)) begin
				issue_request(row.op, row.id, row.cat, row.typed, row.want);
				idle_for(pick_gap(1'b0));
			end
		end

		// random traffic: fill and drain phases keep the queues moving between
		// empty and full
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (n % 60 == 0) begin
				case ($urandom_range(0, 2))
					0: enq_pct = 85;
					1: enq_pct = 50;
					default: enq_pct = 20;
				endcase
			end
			if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
			if (n == NUM_RANDOM / 2) wait_for_outcomes();

			op = ($urandom_range(0, 99) < enq_pct) ? tcpq_pkg::OP_ENQUEUE :
				tcpq_pkg::OP_SERVE;
			r  = $urandom_range(0, 99);
			if (r < 35) cat = tcpq_pkg::CAT_W'($urandom_range(1, 4));
			else if (r < 60) cat = tcpq_pkg::CAT_W'($urandom_range(5, 7));
			else if (r < 85) cat = tcpq_pkg::CAT_LOW;
			else cat = tcpq_pkg::CAT_W'($urandom_range(0, 15));
			issue_request(op, tcpq_pkg::ID_W'($urandom), cat, 1'b0, NO_HAND);
			idle_for(pick_gap(calm));
		end

		wait_for_outcomes();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
			$display("three_class_priority_queue_unit: match");
		end else begin
			$display("three_class_priority_queue_unit: mismatch");
		end
		$finish;
	end

endmodule

[three_class_priority_queue_unit.f]
src/tcpq_pkg.sv
src/tcpq_store.sv
src/tcpq_ctrl.sv
src/three_class_priority_queue_unit.sv
src/tcpq_chk.sv
dv/tb_three_class_priority_queue_unit.sv
